[sv/lvtcp_pkg.sv]
`timescale 1ns / 1ps
package lvtcp_pkg;

    localparam int COORD_W = 32;
    localparam int FRAC_BITS = 16;
    localparam int TRIG_FRAC = 14;
    localparam int T_FRAC = 61 - COORD_W;
    localparam int Q_BITS = 34;
    localparam int K_SPLIT = 20;
    localparam int K_W = 40;
    localparam int PROD_W = 72;

    localparam int ROT_STAGES = 7;
    localparam int CLIP_STAGES = T_FRAC + 3;
    localparam int PROJ_STAGES = Q_BITS + 5;
    localparam int PIPE_STAGES = ROT_STAGES + CLIP_STAGES + PROJ_STAGES + 1;

    localparam logic signed [31:0] NEAR_NEG = -32'sd655;
    localparam logic signed [63:0] COORD_MAX = 64'sd2147483647;
    localparam logic signed [63:0] COORD_MIN = -64'sd2147483648;

    localparam logic [3:0] CFG_CAM_X = 4'd0;
    localparam logic [3:0] CFG_CAM_Y = 4'd1;
    localparam logic [3:0] CFG_CAM_Z = 4'd2;
    localparam logic [3:0] CFG_TRIG_X = 4'd3;
    localparam logic [3:0] CFG_TRIG_Y = 4'd4;
    localparam logic [3:0] CFG_TRIG_Z = 4'd5;
    localparam logic [3:0] CFG_VIEW = 4'd6;
    localparam logic [3:0] CFG_GAIN = 4'd7;

    typedef logic signed [31:0] coord_t;

    typedef struct packed {
        coord_t start_x;
        coord_t start_y;
        coord_t start_z;
        coord_t end_x;
        coord_t end_y;
        coord_t end_z;
    } line_t;

    typedef struct packed {
        coord_t screen_start_x;
        coord_t screen_start_y;
        coord_t screen_end_x;
        coord_t screen_end_y;
        logic   visible;
    } screen_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vec3_t;

    typedef struct packed {
        coord_t      cam_x;
        coord_t      cam_y;
        coord_t      cam_z;
        logic [31:0] trig_x;
        logic [31:0] trig_y;
        logic [31:0] trig_z;
        logic        persp;
        logic [15:0] width;
        logic [15:0] height;
        logic [23:0] gain;
    } cfg_t;

    function automatic coord_t sat_coord(input logic signed [63:0] v);
        coord_t r;
        if (v > COORD_MAX)
        begin
            r = COORD_MAX[31:0];
        end
        else if (v < COORD_MIN)
        begin
            r = COORD_MIN[31:0];
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

[sv/lvtcp_rotate.sv]
`timescale 1ns / 1ps
module lvtcp_rotate
    import lvtcp_pkg::*;
(
    input  logic                  clk,
    input  logic [ROT_STAGES-1:0] en,
    input  cfg_t                  cfg,
    input  vec3_t                 point,
    output vec3_t                 view
);

    typedef struct packed {
        logic signed [47:0] uc;
        logic signed [47:0] vs;
        logic signed [47:0] us;
        logic signed [47:0] vc;
        coord_t             w;
    } prod_t;

    vec3_t       diff_reg;
    vec3_t       diff_next;
    logic [31:0] trig [3];
    vec3_t       rot_in [3];
    vec3_t       rot_out [3];
    coord_t      u_in [3];
    coord_t      v_in [3];
    coord_t      w_in [3];
    prod_t       prod_reg [3];
    prod_t       prod_next [3];
    coord_t      u_reg [3];
    coord_t      u_next [3];
    coord_t      v_reg [3];
    coord_t      v_next [3];
    coord_t      w_reg [3];
    coord_t      w_next [3];

    always_comb
    begin
        diff_next.x = sat_coord(64'(point.x) - 64'(cfg.cam_x));
        diff_next.y = sat_coord(64'(point.y) - 64'(cfg.cam_y));
        diff_next.z = sat_coord(64'(point.z) - 64'(cfg.cam_z));
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            diff_reg <= diff_next;
        end
    end

    // Rotation order is z, then y, then x; each one turns the pair (u, v) and keeps w.
    always_comb
    begin
        trig[0] = cfg.trig_z;
        trig[1] = cfg.trig_y;
        trig[2] = cfg.trig_x;
        rot_out[0] = '{x: u_reg[0], y: v_reg[0], z: w_reg[0]};
        rot_out[1] = '{x: v_reg[1], y: w_reg[1], z: u_reg[1]};
        rot_out[2] = '{x: w_reg[2], y: u_reg[2], z: v_reg[2]};
        rot_in[0] = diff_reg;
        rot_in[1] = rot_out[0];
        rot_in[2] = rot_out[1];
        u_in[0] = rot_in[0].x;
        v_in[0] = rot_in[0].y;
        w_in[0] = rot_in[0].z;
        u_in[1] = rot_in[1].z;
        v_in[1] = rot_in[1].x;
        w_in[1] = rot_in[1].y;
        u_in[2] = rot_in[2].y;
        v_in[2] = rot_in[2].z;
        w_in[2] = rot_in[2].x;
    end

    for (genvar r = 0; r < 3; r++)
    begin : g_rot
        logic signed [15:0] sn;
        logic signed [15:0] cs;
        logic signed [48:0] sum_u;
        logic signed [48:0] sum_v;

        assign sn = trig[r][31:16];
        assign cs = trig[r][15:0];

        always_comb
        begin
            prod_next[r].uc = 48'(u_in[r]) * 48'(cs);
            prod_next[r].vs = 48'(v_in[r]) * 48'(sn);
            prod_next[r].us = 48'(u_in[r]) * 48'(sn);
            prod_next[r].vc = 48'(v_in[r]) * 48'(cs);
            prod_next[r].w  = w_in[r];
        end

        always_comb
        begin
            sum_u = 49'(prod_reg[r].uc) - 49'(prod_reg[r].vs)
                    + 49'sd8192;
            sum_v = 49'(prod_reg[r].us) + 49'(prod_reg[r].vc)
                    + 49'sd8192;
            u_next[r] = sat_coord(64'(sum_u >>> TRIG_FRAC));
            v_next[r] = sat_coord(64'(sum_v >>> TRIG_FRAC));
            w_next[r] = prod_reg[r].w;
        end

        always_ff @(posedge clk)
        begin
            if (en[1 + 2 * r])
            begin
                prod_reg[r] <= prod_next[r];
            end
            if (en[2 + 2 * r])
            begin
                u_reg[r] <= u_next[r];
                v_reg[r] <= v_next[r];
                w_reg[r] <= w_next[r];
            end
        end
    end

    assign view = rot_out[2];

endmodule

[sv/lvtcp_clip.sv]
`timescale 1ns / 1ps
module lvtcp_clip
    import lvtcp_pkg::*;
(
    input  logic                   clk,
    input  logic [CLIP_STAGES-1:0] en,
    input  logic                   persp,
    input  vec3_t                  a,
    input  vec3_t                  b,
    output vec3_t                  a_out,
    output vec3_t                  b_out,
    output logic                   visible
);

    typedef struct packed {
        vec3_t               a;
        vec3_t               b;
        logic                clip;
        logic                clip_a;
        logic                discard;
        logic signed [32:0]  dx;
        logic signed [32:0]  dy;
        logic [32:0]         den;
        logic [32:0]         rem;
        logic [T_FRAC-1:0]   t;
    } clip_st_t;

    clip_st_t           st_reg [T_FRAC+1];
    clip_st_t           st_next [T_FRAC+1];
    vec3_t              ma_reg;
    vec3_t              mb_reg;
    logic               mclip_reg;
    logic               mclip_a_reg;
    logic               mdiscard_reg;
    logic signed [62:0] mx_reg;
    logic signed [62:0] my_reg;
    logic signed [62:0] mx_next;
    logic signed [62:0] my_next;
    logic               ain;
    logic               bin;
    vec3_t              n_in;
    vec3_t              o_in;
    logic signed [32:0] dz;
    logic signed [32:0] num;
    vec3_t              n_fin;
    vec3_t              clipped;
    logic signed [62:0] off_x;
    logic signed [62:0] off_y;
    logic signed [63:0] sum_x;
    logic signed [63:0] sum_y;
    vec3_t              a_out_reg;
    vec3_t              a_out_next;
    vec3_t              b_out_reg;
    vec3_t              b_out_next;
    logic               visible_reg;
    logic               visible_next;

    always_comb
    begin
        ain = a.z <= NEAR_NEG;
        bin = b.z <= NEAR_NEG;
        st_next[0].a = a;
        st_next[0].b = b;
        st_next[0].clip = persp && (ain != bin);
        st_next[0].clip_a = !ain;
        st_next[0].discard = persp && !ain && !bin;
        n_in = ain ? a : b;
        o_in = ain ? b : a;
        st_next[0].dx = 33'(o_in.x) - 33'(n_in.x);
        st_next[0].dy = 33'(o_in.y) - 33'(n_in.y);
        dz = 33'(o_in.z) - 33'(n_in.z);
        num = 33'(NEAR_NEG) - 33'(n_in.z);
        st_next[0].den = dz;
        st_next[0].rem = num;
        st_next[0].t = '0;
    end

    for (genvar i = 1; i <= T_FRAC; i++)
    begin : g_div
        logic [33:0] rem2;
        logic        ge;

        always_comb
        begin
            rem2 = {st_reg[i-1].rem, 1'b0};
            ge = rem2 >= {1'b0, st_reg[i-1].den};
            st_next[i] = st_reg[i-1];
            st_next[i].rem = ge ? 33'(rem2 - {1'b0, st_reg[i-1].den}) : rem2[32:0];
            st_next[i].t = {st_reg[i-1].t[T_FRAC-2:0], ge};
        end
    end

    for (genvar i = 0; i <= T_FRAC; i++)
    begin : g_st
        always_ff @(posedge clk)
        begin
            if (en[i])
            begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    always_comb
    begin
        mx_next = 63'(st_reg[T_FRAC].dx) * 63'($signed({1'b0, st_reg[T_FRAC].t}));
        my_next = 63'(st_reg[T_FRAC].dy) * 63'($signed({1'b0, st_reg[T_FRAC].t}));
    end

    always_ff @(posedge clk)
    begin
        if (en[T_FRAC+1])
        begin
            ma_reg <= st_reg[T_FRAC].a;
            mb_reg <= st_reg[T_FRAC].b;
            mclip_reg <= st_reg[T_FRAC].clip;
            mclip_a_reg <= st_reg[T_FRAC].clip_a;
            mdiscard_reg <= st_reg[T_FRAC].discard;
            mx_reg <= mx_next;
            my_reg <= my_next;
        end
    end

    always_comb
    begin
        n_fin = mclip_a_reg ? mb_reg : ma_reg;
        off_x = (mx_reg + (63'sd1 <<< (T_FRAC - 1))) >>> T_FRAC;
        off_y = (my_reg + (63'sd1 <<< (T_FRAC - 1))) >>> T_FRAC;
        sum_x = 64'(n_fin.x) + 64'(off_x);
        sum_y = 64'(n_fin.y) + 64'(off_y);
        clipped = '{x: sum_x[31:0], y: sum_y[31:0], z: NEAR_NEG};
        a_out_next = (mclip_reg && mclip_a_reg) ? clipped : ma_reg;
        b_out_next = (mclip_reg && !mclip_a_reg) ? clipped : mb_reg;
        visible_next = !mdiscard_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[T_FRAC+2])
        begin
            a_out_reg <= a_out_next;
            b_out_reg <= b_out_next;
            visible_reg <= visible_next;
        end
    end

    assign a_out = a_out_reg;
    assign b_out = b_out_reg;
    assign visible = visible_reg;

endmodule

[sv/lvtcp_project.sv]
`timescale 1ns / 1ps
module lvtcp_project
    import lvtcp_pkg::*;
(
    input  logic                   clk,
    input  logic [PROJ_STAGES-1:0] en,
    input  cfg_t                   cfg,
    input  coord_t                 coord,
    input  coord_t                 depth,
    input  logic                   flip,
    input  logic [31:0]            centre,
    output coord_t                 result
);

    typedef struct packed {
        logic [32:0]       dv;
        logic [32:0]       rem;
        logic [Q_BITS-1:0] q;
        logic [Q_BITS-1:0] rest;
        logic              sneg;
        logic              cap;
    } lane_st_t;

    localparam logic [32:0] ORTHO_DEN = 33'd1 << FRAC_BITS;

    logic [31:0]           mag_reg;
    logic [31:0]           mag_next;
    logic [K_W-1:0]        k_reg;
    logic [K_W-1:0]        k_next;
    logic [32:0]           dv0_reg;
    logic [32:0]           dv0_next;
    logic                  sneg0_reg;
    logic                  sneg0_next;
    logic [51:0]           plo_reg;
    logic [51:0]           plo_next;
    logic [51:0]           phi_reg;
    logic [51:0]           phi_next;
    logic [32:0]           dv1_reg;
    logic                  sneg1_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [PROD_W-1:0]     prod_next;
    logic [32:0]           dv2_reg;
    logic                  sneg2_reg;
    lane_st_t              st_reg [Q_BITS+1];
    lane_st_t              st_next [Q_BITS+1];
    logic [PROD_W-Q_BITS-1:0] top;
    logic [31:0]           zabs;
    logic [Q_BITS:0]       magq;
    logic                  round_up;
    logic signed [36:0]    sum;
    coord_t                result_reg;
    coord_t                result_next;

    always_comb
    begin
        mag_next = coord[31] ? (~$unsigned(coord) + 32'd1) : $unsigned(coord);
        zabs = ~$unsigned(depth) + 32'd1;
        k_next = cfg.persp ? (K_W'(cfg.height) * K_W'(cfg.gain)) : K_W'(cfg.gain);
        dv0_next = cfg.persp ? {zabs, 1'b0} : ORTHO_DEN;
        sneg0_next = coord[31] ^ flip;
    end

    always_comb
    begin
        plo_next = 52'(mag_reg) * 52'(k_reg[K_SPLIT-1:0]);
        phi_next = 52'(mag_reg) * 52'(k_reg[K_W-1:K_SPLIT]);
    end

    always_comb
    begin
        prod_next = PROD_W'(plo_reg) + (PROD_W'(phi_reg) << K_SPLIT);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            mag_reg <= mag_next;
            k_reg <= k_next;
            dv0_reg <= dv0_next;
            sneg0_reg <= sneg0_next;
        end
        if (en[1])
        begin
            plo_reg <= plo_next;
            phi_reg <= phi_next;
            dv1_reg <= dv0_reg;
            sneg1_reg <= sneg0_reg;
        end
        if (en[2])
        begin
            prod_reg <= prod_next;
            dv2_reg <= dv1_reg;
            sneg2_reg <= sneg1_reg;
        end
    end

    // A quotient that reaches the cap saturates the screen coordinate in any case.
    always_comb
    begin
        top = prod_reg[PROD_W-1:Q_BITS];
        st_next[0].dv = dv2_reg;
        st_next[0].cap = top >= (PROD_W-Q_BITS)'(dv2_reg);
        st_next[0].rem = top[32:0];
        st_next[0].rest = prod_reg[Q_BITS-1:0];
        st_next[0].q = '0;
        st_next[0].sneg = sneg2_reg;
    end

    for (genvar i = 1; i <= Q_BITS; i++)
    begin : g_div
        logic [33:0] rem2;
        logic        ge;

        always_comb
        begin
            rem2 = {st_reg[i-1].rem, st_reg[i-1].rest[Q_BITS-1]};
            ge = rem2 >= {1'b0, st_reg[i-1].dv};
            st_next[i] = st_reg[i-1];
            st_next[i].rem = ge ? 33'(rem2 - {1'b0, st_reg[i-1].dv}) : rem2[32:0];
            st_next[i].q = {st_reg[i-1].q[Q_BITS-2:0], ge};
            st_next[i].rest = {st_reg[i-1].rest[Q_BITS-2:0], 1'b0};
        end
    end

    for (genvar i = 0; i <= Q_BITS; i++)
    begin : g_st
        always_ff @(posedge clk)
        begin
            if (en[3 + i])
            begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    always_comb
    begin
        round_up = {st_reg[Q_BITS].rem, 1'b0} >= {1'b0, st_reg[Q_BITS].dv};
        if (st_reg[Q_BITS].cap)
        begin
            magq = (Q_BITS+1)'(1) << Q_BITS;
        end
        else
        begin
            magq = (Q_BITS+1)'(st_reg[Q_BITS].q) + (Q_BITS+1)'(round_up);
        end
        if (st_reg[Q_BITS].sneg)
        begin
            sum = $signed({5'b0, centre}) - $signed({2'b0, magq});
        end
        else
        begin
            sum = $signed({5'b0, centre}) + $signed({2'b0, magq});
        end
        result_next = sat_coord(64'(sum));
    end

    always_ff @(posedge clk)
    begin
        if (en[PROJ_STAGES-1])
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

[sv/line_view_transform_clip_project_core.sv]
`timescale 1ns / 1ps
// Throughput: one item per cycle while screen_stall is low; the rate is set by the
// fully pipelined datapath, with one stage per quotient bit in the clip divider and the
// four projection dividers. Each stage advances on its own, so bubbles close up while
// the output is stalled. Reset clears the pipeline valid bits and loads the
// configuration reset values.
module line_view_transform_clip_project_core
    import lvtcp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        line_valid,
    output logic        line_stall,
    input  line_t       line_item,
    output logic        screen_valid,
    input  logic        screen_stall,
    output screen_t     screen_item,
    input  logic        cfg_write,
    input  logic [3:0]  cfg_index,
    input  logic [32:0] cfg_data
);

    localparam int CLIP_BASE = ROT_STAGES;
    localparam int PROJ_BASE = ROT_STAGES + CLIP_STAGES;
    localparam int MERGE_STAGE = PIPE_STAGES - 1;

    localparam cfg_t CFG_RESET = '{
        cam_x: '0, cam_y: '0, cam_z: '0,
        trig_x: 32'd16384, trig_y: 32'd16384, trig_z: 32'd16384,
        persp: 1'b0, width: 16'd800, height: 16'd600, gain: 24'd65536
    };

    cfg_t                   cfg_reg;
    cfg_t                   cfg_next;
    logic [PIPE_STAGES-1:0] valid_reg;
    logic [PIPE_STAGES-1:0] valid_next;
    logic [PIPE_STAGES-1:0] en;
    vec3_t                  view_a;
    vec3_t                  view_b;
    vec3_t                  clip_a;
    vec3_t                  clip_b;
    logic                   clip_visible;
    logic                   vis_reg [PROJ_STAGES];
    logic [31:0]            centre_x;
    logic [31:0]            centre_y;
    coord_t                 ssx;
    coord_t                 ssy;
    coord_t                 sex;
    coord_t                 sey;
    screen_t                out_reg;
    screen_t                out_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_CAM_X: cfg_next.cam_x = cfg_data[31:0];
                CFG_CAM_Y: cfg_next.cam_y = cfg_data[31:0];
                CFG_CAM_Z: cfg_next.cam_z = cfg_data[31:0];
                CFG_TRIG_X: cfg_next.trig_x = cfg_data[31:0];
                CFG_TRIG_Y: cfg_next.trig_y = cfg_data[31:0];
                CFG_TRIG_Z: cfg_next.trig_z = cfg_data[31:0];
                CFG_VIEW:
                begin
                    cfg_next.persp = cfg_data[32];
                    cfg_next.width = cfg_data[31:16];
                    cfg_next.height = cfg_data[15:0];
                end
                CFG_GAIN: cfg_next.gain = cfg_data[23:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        en[PIPE_STAGES-1] = !valid_reg[PIPE_STAGES-1] || !screen_stall;
        for (int s = PIPE_STAGES - 2; s >= 0; s--)
        begin
            en[s] = !valid_reg[s] || en[s+1];
        end
        valid_next[0] = en[0] ? line_valid : valid_reg[0];
        for (int s = 1; s < PIPE_STAGES; s++)
        begin
            valid_next[s] = en[s] ? valid_reg[s-1] : valid_reg[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
            valid_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
            valid_reg <= valid_next;
        end
    end

    assign line_stall = !en[0];

    lvtcp_rotate u_rot_start (
        .clk   (clk),
        .en    (en[ROT_STAGES-1:0]),
        .cfg   (cfg_reg),
        .point ('{x: line_item.start_x, y: line_item.start_y, z: line_item.start_z}),
        .view  (view_a)
    );

    lvtcp_rotate u_rot_end (
        .clk   (clk),
        .en    (en[ROT_STAGES-1:0]),
        .cfg   (cfg_reg),
        .point ('{x: line_item.end_x, y: line_item.end_y, z: line_item.end_z}),
        .view  (view_b)
    );

    lvtcp_clip u_clip (
        .clk     (clk),
        .en      (en[PROJ_BASE-1:CLIP_BASE]),
        .persp   (cfg_reg.persp),
        .a       (view_a),
        .b       (view_b),
        .a_out   (clip_a),
        .b_out   (clip_b),
        .visible (clip_visible)
    );

    assign centre_x = 32'({cfg_reg.width, {(FRAC_BITS - 1){1'b0}}});
    assign centre_y = 32'({cfg_reg.height, {(FRAC_BITS - 1){1'b0}}});

    lvtcp_project u_proj_ssx (
        .clk    (clk),
        .en     (en[MERGE_STAGE-1:PROJ_BASE]),
        .cfg    (cfg_reg),
        .coord  (clip_a.x),
        .depth  (clip_a.z),
        .flip   (1'b0),
        .centre (centre_x),
        .result (ssx)
    );

    lvtcp_project u_proj_ssy (
        .clk    (clk),
        .en     (en[MERGE_STAGE-1:PROJ_BASE]),
        .cfg    (cfg_reg),
        .coord  (clip_a.y),
        .depth  (clip_a.z),
        .flip   (1'b1),
        .centre (centre_y),
        .result (ssy)
    );

    lvtcp_project u_proj_sex (
        .clk    (clk),
        .en     (en[MERGE_STAGE-1:PROJ_BASE]),
        .cfg    (cfg_reg),
        .coord  (clip_b.x),
        .depth  (clip_b.z),
        .flip   (1'b0),
        .centre (centre_x),
        .result (sex)
    );

    lvtcp_project u_proj_sey (
        .clk    (clk),
        .en     (en[MERGE_STAGE-1:PROJ_BASE]),
        .cfg    (cfg_reg),
        .coord  (clip_b.y),
        .depth  (clip_b.z),
        .flip   (1'b1),
        .centre (centre_y),
        .result (sey)
    );

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < PROJ_STAGES; s++)
        begin
            if (en[PROJ_BASE + s])
            begin
                vis_reg[s] <= (s == 0) ? clip_visible : vis_reg[(s == 0) ? 0 : s - 1];
            end
        end
    end

    // A discarded segment reports zero coordinates.
    always_comb
    begin
        out_next.visible = vis_reg[PROJ_STAGES-1];
        out_next.screen_start_x = vis_reg[PROJ_STAGES-1] ? ssx : '0;
        out_next.screen_start_y = vis_reg[PROJ_STAGES-1] ? ssy : '0;
        out_next.screen_end_x = vis_reg[PROJ_STAGES-1] ? sex : '0;
        out_next.screen_end_y = vis_reg[PROJ_STAGES-1] ? sey : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en[MERGE_STAGE])
        begin
            out_reg <= out_next;
        end
    end

    assign screen_valid = valid_reg[MERGE_STAGE];
    assign screen_item = out_reg;

endmodule

[tb/sv/tb_line_view_transform_clip_project_core.sv]
`timescale 1ns / 1ps
module tb_line_view_transform_clip_project_core;
    import lvtcp_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 120;
    localparam int RANDOM_PHASES = 12;
    localparam int ITEMS_PER_PHASE = 140;
    localparam logic [32:0] VIEW_ORTHO = 33'h0_0320_0258;
    localparam logic [32:0] VIEW_PERSP = 33'h1_0320_0258;

    typedef struct packed {
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] z;
    } wpt_t;

    typedef struct {
        bit      persp;
        line_t   line;
        bit      typed;
        screen_t screen;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        line_valid;
    logic        line_stall;
    line_t       line_item;
    logic        screen_valid;
    logic        screen_stall;
    screen_t     screen_item;
    logic        cfg_write;
    logic [3:0]  cfg_index;
    logic [32:0] cfg_data;

    coord_t      cam_x_m;
    coord_t      cam_y_m;
    coord_t      cam_z_m;
    logic [31:0] trig_x_m;
    logic [31:0] trig_y_m;
    logic [31:0] trig_z_m;
    logic        persp_m;
    logic [15:0] width_m;
    logic [15:0] height_m;
    logic [23:0] gain_m;

    screen_t     expected_screens[$];
    int          errors;
    int          idle_cycles;
    int          burst_left;
    int          stall_mode;
    int          stall_cycle;
    row_t        rows[15];

    line_view_transform_clip_project_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .line_valid   (line_valid),
        .line_stall   (line_stall),
        .line_item    (line_item),
        .screen_valid (screen_valid),
        .screen_stall (screen_stall),
        .screen_item  (screen_item),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic logic signed [63:0] clamp32(input logic signed [127:0] v);
        if (v > 128'sh7FFFFFFF)
        begin
            return 64'sh7FFFFFFF;
        end
        if (v < -128'sh80000000)
        begin
            return -64'sh80000000;
        end
        return v[63:0];
    endfunction

    function automatic logic signed [63:0] round_pair(input logic signed [127:0] p1,
                                                      input logic signed [127:0] p2);
        logic signed [127:0] s;
        s = (p1 + p2 + 128'sd8192) >>> TRIG_FRAC;
        return clamp32(s);
    endfunction

    function automatic wpt_t to_view(input coord_t wx, input coord_t wy, input coord_t wz);
        logic signed [127:0] x, y, z, s, c, nx, ny, nz;
        wpt_t p;
        x = wx;
        y = wy;
        z = wz;
        x = clamp32(x - cam_x_m);
        y = clamp32(y - cam_y_m);
        z = clamp32(z - cam_z_m);
        s = $signed(trig_z_m[31:16]);
        c = $signed(trig_z_m[15:0]);
        nx = round_pair(x * c, -(y * s));
        ny = round_pair(x * s, y * c);
        x = nx;
        y = ny;
        s = $signed(trig_y_m[31:16]);
        c = $signed(trig_y_m[15:0]);
        nx = round_pair(x * c, z * s);
        nz = round_pair(z * c, -(x * s));
        x = nx;
        z = nz;
        s = $signed(trig_x_m[31:16]);
        c = $signed(trig_x_m[15:0]);
        ny = round_pair(y * c, -(z * s));
        nz = round_pair(y * s, z * c);
        p.x = x;
        p.y = ny;
        p.z = nz;
        return p;
    endfunction

    function automatic wpt_t clip_to_near(input wpt_t n, input wpt_t o);
        logic signed [127:0] num, den, t, d;
        wpt_t r;
        num = NEAR_NEG;
        num = num - n.z;
        den = o.z;
        den = den - n.z;
        t = (num <<< T_FRAC) / den;
        d = o.x;
        d = d - n.x;
        r.x = n.x + ((d * t + (128'sd1 <<< (T_FRAC - 1))) >>> T_FRAC);
        d = o.y;
        d = d - n.y;
        r.y = n.y + ((d * t + (128'sd1 <<< (T_FRAC - 1))) >>> T_FRAC);
        r.z = NEAR_NEG;
        return r;
    endfunction

    function automatic coord_t place(input logic signed [127:0] centre,
                                     input logic signed [127:0] v,
                                     input logic [127:0] k, input logic [127:0] den,
                                     input bit neg);
        logic [127:0] mag, prod, q, r;
        logic signed [127:0] sq;
        logic signed [63:0] res;
        mag = (v < 0) ? -v : v;
        prod = mag * k;
        q = prod / den;
        r = prod % den;
        if (q >= (128'd1 << 62))
        begin
            q = 128'd1 << 62;
        end
        else if (r >= den - r)
        begin
            q = q + 1;
        end
        sq = q;
        if ((v < 0) != neg)
        begin
            sq = -sq;
        end
        res = clamp32(centre + sq);
        return res[31:0];
    endfunction

    function automatic void project(input wpt_t p, output coord_t ox, output coord_t oy);
        logic signed [127:0] cx, cy, px, py, za;
        logic [127:0] k, den;
        cx = {112'd0, width_m} << (FRAC_BITS - 1);
        cy = {112'd0, height_m} << (FRAC_BITS - 1);
        k = gain_m;
        den = 128'd1 << 16;
        if (persp_m)
        begin
            za = p.z;
            za = -za;
            k = height_m * gain_m;
            den = za << (17 - FRAC_BITS);
        end
        px = p.x;
        py = p.y;
        ox = place(cx, px, k, den, 1'b0);
        oy = place(cy, py, k, den, 1'b1);
    endfunction

    function automatic screen_t predict_screen(input line_t li);
        wpt_t a, b;
        screen_t s;
        bit a_in, b_in;
        a = to_view(li.start_x, li.start_y, li.start_z);
        b = to_view(li.end_x, li.end_y, li.end_z);
        s = '0;
        if (persp_m)
        begin
            a_in = a.z <= NEAR_NEG;
            b_in = b.z <= NEAR_NEG;
            if (!a_in && !b_in)
            begin
                return s;
            end
            if (a_in && !b_in)
            begin
                b = clip_to_near(a, b);
            end
            else if (!a_in)
            begin
                a = clip_to_near(b, a);
            end
        end
        project(a, s.screen_start_x, s.screen_start_y);
        project(b, s.screen_end_x, s.screen_end_y);
        s.visible = 1'b1;
        return s;
    endfunction

    task automatic load_reset_model();
        cam_x_m = '0;
        cam_y_m = '0;
        cam_z_m = '0;
        trig_x_m = 32'd16384;
        trig_y_m = 32'd16384;
        trig_z_m = 32'd16384;
        {persp_m, width_m, height_m} = VIEW_ORTHO;
        gain_m = 24'd65536;
    endtask

    task automatic wait_idle();
        while (expected_screens.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [3:0] idx, input logic [32:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_CAM_X: cam_x_m = value[31:0];
            CFG_CAM_Y: cam_y_m = value[31:0];
            CFG_CAM_Z: cam_z_m = value[31:0];
            CFG_TRIG_X: trig_x_m = value[31:0];
            CFG_TRIG_Y: trig_y_m = value[31:0];
            CFG_TRIG_Z: trig_z_m = value[31:0];
            CFG_VIEW: {persp_m, width_m, height_m} = value;
            CFG_GAIN: gain_m = value[23:0];
            default: ;
        endcase
    endtask

    task automatic send_line(input line_t li, input bit typed, input screen_t exp_screen);
        screen_t queued;
        line_item <= li;
        line_valid <= 1'b1;
        do
        begin
            @(negedge clk);
        end
        while (line_stall);
        @(posedge clk);
        queued = typed ? exp_screen : predict_screen(li);
        expected_screens = {expected_screens, queued};
        burst_left = burst_left - 1;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0)
            begin
                line_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    endtask

    function automatic logic [31:0] random_trig();
        real ang;
        int s, c;
        if ($urandom_range(0, 3) == 0)
        begin
            return $urandom;
        end
        ang = $urandom_range(0, 62831) / 10000.0;
        s = $rtoi($sin(ang) * 16384.0);
        c = $rtoi($cos(ang) * 16384.0);
        return {s[15:0], c[15:0]};
    endfunction

    function automatic logic [31:0] random_cam();
        if ($urandom_range(0, 3) == 0)
        begin
            return $urandom;
        end
        return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
    endfunction

    function automatic coord_t near_value(input coord_t base);
        logic signed [63:0] v;
        v = base;
        v = v + $signed($urandom_range(0, 32'h0080_0000)) - 64'sh0040_0000;
        return clamp32(v);
    endfunction

    task automatic configure_phase(input int phase);
        logic [32:0] view;
        logic [32:0] gain;
        view = {$urandom_range(0, 1) == 1, 16'($urandom), 16'($urandom)};
        if ($urandom_range(0, 2) != 0)
        begin
            view[31:0] = {16'($urandom_range(1, 2048)), 16'($urandom_range(1, 2048))};
        end
        gain = $urandom_range(0, 24'hFFFFFF);
        if ($urandom_range(0, 1) == 1)
        begin
            gain = $urandom_range(24'h004000, 24'h040000);
        end
        write_reg(CFG_CAM_X, {1'b0, random_cam()});
        write_reg(CFG_CAM_Y, {1'b0, random_cam()});
        write_reg(CFG_CAM_Z, {1'b0, random_cam()});
        write_reg(CFG_TRIG_X, {1'b0, random_trig()});
        write_reg(CFG_TRIG_Y, {1'b0, random_trig()});
        write_reg(CFG_TRIG_Z, {1'b0, random_trig()});
        write_reg(CFG_VIEW, view);
        write_reg(CFG_GAIN, {$urandom_range(0, 1) == 1, 8'($urandom), gain[23:0]});
        write_reg(CFG_GAIN + 4'($urandom_range(1, 8)), {1'b1, 32'($urandom)});
        if (phase == 0)
        begin
            write_reg(CFG_CAM_X, 33'h0_7FFF_FFFF);
            write_reg(CFG_CAM_Z, 33'h1_8000_0000);
            write_reg(CFG_TRIG_Y, 33'h0_FFFF_FFFF);
            write_reg(CFG_VIEW, 33'h1_FFFF_FFFF);
            write_reg(CFG_GAIN, 33'h1_FFFF_FFFF);
        end
        else if (phase == 1)
        begin
            write_reg(CFG_CAM_Y, 33'h0_8000_0000);
            write_reg(CFG_TRIG_X, 33'h0_8000_8000);
            write_reg(CFG_VIEW, 33'h1_0000_0000);
            write_reg(CFG_GAIN, 33'h0_0000_0000);
        end
        else if (phase == 2)
        begin
            write_reg(CFG_VIEW, 33'h0_0000_0000);
        end
    endtask

    function automatic line_t random_line();
        line_t li;
        if ($urandom_range(0, 6) == 0)
        begin
            li = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        end
        else
        begin
            li.start_x = near_value(cam_x_m);
            li.start_y = near_value(cam_y_m);
            li.start_z = near_value(cam_z_m);
            li.end_x = near_value(cam_x_m);
            li.end_y = near_value(cam_y_m);
            li.end_z = near_value(cam_z_m);
        end
        return li;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((line_valid && !line_stall) || (screen_valid && !screen_stall))
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    always @(posedge clk)
    begin
        stall_cycle = stall_cycle + 1;
        if (stall_cycle % 300 == 0)
        begin
            stall_mode = $urandom_range(0, 3);
        end
        case (stall_mode)
            0: screen_stall <= 1'b0;
            1: screen_stall <= ($urandom_range(0, 3) == 0);
            2: screen_stall <= ($urandom_range(0, 9) < 7);
            default: screen_stall <= (stall_cycle % 5 < 2);
        endcase
    end

    task automatic check_field(input string field, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            errors = errors + 1;
            $display("%0t: %s expected %h actual %h", $time, field, exp_v, act_v);
        end
    endtask

    always @(posedge clk)
    begin
        screen_t exp_screen;
        if (rst_n && screen_valid && !screen_stall)
        begin
            if (expected_screens.size() == 0)
            begin
                errors = errors + 1;
                $display("%0t: unexpected item, expected none actual %h", $time, screen_item);
            end
            else
            begin
                exp_screen = expected_screens.pop_front();
                check_field("screen_start_x", exp_screen.screen_start_x,
                            screen_item.screen_start_x);
                check_field("screen_start_y", exp_screen.screen_start_y,
                            screen_item.screen_start_y);
                check_field("screen_end_x", exp_screen.screen_end_x, screen_item.screen_end_x);
                check_field("screen_end_y", exp_screen.screen_end_y, screen_item.screen_end_y);
                check_field("visible", {31'd0, exp_screen.visible}, {31'd0, screen_item.visible});
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        line_valid = 1'b0;
        line_item = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        screen_stall = 1'b0;
        errors = 0;
        idle_cycles = 0;
        burst_left = 1;
        stall_mode = 0;
        stall_cycle = 0;
        load_reset_model();

        rows[0] = '{0, {32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}, 1,
                    {32'h0190_0000, 32'h012C_0000, 32'h0190_0000, 32'h012C_0000, 1'b1}};
        rows[1] = '{0, {32'h0001_0000, 32'h0001_0000, 32'h0, 32'hFFFF_0000, 32'hFFFF_0000,
                    32'h0}, 1,
                    {32'h0191_0000, 32'h012B_0000, 32'h018F_0000, 32'h012D_0000, 1'b1}};
        rows[2] = '{0, {6{32'h7FFF_FFFF}}, 0, '0};
        rows[3] = '{0, {6{32'h8000_0000}}, 0, '0};
        rows[4] = '{0, {{3{32'h7FFF_FFFF}}, {3{32'h8000_0000}}}, 0, '0};
        rows[5] = '{1, {32'h0001_0000, 32'h0, 32'h0002_0000, 32'h0, 32'h0001_0000,
                    32'h0002_0000}, 1, '0};
        rows[6] = '{1, {32'h0001_0000, 32'h0001_0000, 32'hFFFE_0000, 32'hFFFF_0000,
                    32'hFFFF_0000, 32'hFFFE_0000}, 0, '0};
        rows[7] = '{1, {32'h0001_0000, 32'h0001_0000, 32'hFFFE_0000, 32'hFFFF_0000,
                    32'hFFFF_0000, 32'h0002_0000}, 0, '0};
        rows[8] = '{1, {32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000,
                    32'hFFFF_0000, 32'hFFFE_0000}, 0, '0};
        rows[9] = '{1, {32'h0001_0000, 32'h0, 32'hFFFF_FD71, 32'h0, 32'h0001_0000,
                    32'hFFFF_FD71}, 0, '0};
        rows[10] = '{1, {32'h0001_0000, 32'h0, 32'hFFFF_FD72, 32'h0, 32'h0001_0000,
                     32'hFFFF_FD72}, 1, '0};
        rows[11] = '{1, {32'h0001_0000, 32'h0, 32'hFFFF_FD71, 32'h0, 32'h0001_0000,
                     32'hFFFF_FD72}, 0, '0};
        rows[12] = '{1, {32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h7FFF_FFFF, 32'hFFFF_0000}, 0, '0};
        rows[13] = '{1, {6{32'h0}}, 1, '0};
        rows[14] = '{1, {32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FD71, 32'h8000_0000,
                     32'h8000_0000, 32'hFFFF_FD71}, 0, '0};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].persp != persp_m)
            begin
                line_valid <= 1'b0;
                @(posedge clk);
                wait_idle();
                write_reg(CFG_VIEW, rows[i].persp ? VIEW_PERSP : VIEW_ORTHO);
            end
            send_line(rows[i].line, rows[i].typed, rows[i].screen);
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            line_valid <= 1'b0;
            @(posedge clk);
            wait_idle();
            configure_phase(phase);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                send_line(random_line(), 1'b0, '0);
            end
        end

        line_valid <= 1'b0;
        wait_idle();
        if (errors == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[files.f]
sv/lvtcp_pkg.sv
sv/lvtcp_rotate.sv
sv/lvtcp_clip.sv
sv/lvtcp_project.sv
sv/line_view_transform_clip_project_core.sv
tb/sv/tb_line_view_transform_clip_project_core.sv
